### design/vpls_pkg.sv
// vpls_pkg: constants, types and helpers for the vertex point-light shader
// no dependencies; imported by the interfaces and every module of the block
package vpls_pkg;

   localparam int WORLD_COLS       = 8;
   localparam int WORLD_ROWS       = 8;
   localparam int LIGHTS_PER_CHUNK = 4;

   localparam int CHUNKS    = WORLD_COLS * WORLD_ROWS;
   localparam int CHUNK_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int SLOT_W    = (LIGHTS_PER_CHUNK > 1) ? $clog2(LIGHTS_PER_CHUNK) : 1;
   localparam int COUNT_W   = $clog2(LIGHTS_PER_CHUNK + 1);

   localparam int POS_W     = 16;
   localparam int COLOR_W   = 16;
   localparam int NIB_W     = 4;
   localparam int FALLOFF_W = 4;
   localparam int REACH_W   = 34;
   localparam int MAG_W     = 16;
   localparam int SQ_W      = 32;
   localparam int DIST_W    = 34;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 34;

   localparam int PROBES      = 9;
   localparam int PROBE_CNT_W = 4;

   localparam logic [REACH_W-1:0] REACH_RESET = 34'd65536;

   typedef enum logic [1:0] {
      CMD_SHADE = 2'd0,
      CMD_LIGHT = 2'd1,
      CMD_COUNT = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FALLOFF = 1'b0,
      CSR_REACH   = 1'b1
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_DONE
   } state_type;

   typedef logic signed [POS_W-1:0] pos_type;

   typedef struct packed {
      pos_type z;
      pos_type y;
      pos_type x;
   } light_type;

   typedef struct packed {
      logic                        valid;
      logic [LIGHTS_PER_CHUNK-1:0] live;
   } probe_type;

   typedef struct packed {
      logic valid;
      logic hit;
   } verdict_type;

   function automatic logic [MAG_W-1:0] abs_diff(input pos_type a, input pos_type b);
      logic signed [POS_W:0] d;
      d = (POS_W+1)'(a) - (POS_W+1)'(b);
      return d[POS_W] ? MAG_W'(-d) : MAG_W'(d);
   endfunction

   function automatic logic [NIB_W-1:0] sat_sub(input logic [NIB_W-1:0] ch,
                                                input logic [FALLOFF_W-1:0] amt);
      return (ch > amt) ? NIB_W'(ch - amt) : '0;
   endfunction

endpackage

### design/vpls_if.sv
// vpls_if: valid/ready channel interfaces for requests, responses and csr writes
// depends on vpls_pkg
interface vpls_req_if import vpls_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [1:0]      command;
   logic [2:0]      home_col;
   logic [2:0]      home_row;
   logic [1:0]      slot;
   pos_type         pos_x;
   pos_type         pos_y;
   pos_type         pos_z;
   logic [COLOR_W-1:0] color_in;
   logic [2:0]      count_in;

   modport source (output valid, command, home_col, home_row, slot, pos_x, pos_y, pos_z,
                   color_in, count_in, input ready);
   modport sink   (input valid, command, home_col, home_row, slot, pos_x, pos_y, pos_z,
                   color_in, count_in, output ready);
endinterface

interface vpls_rsp_if import vpls_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] color_out;
   logic               lit;

   modport source (output valid, color_out, lit, input ready);
   modport sink   (input valid, color_out, lit, output ready);
endinterface

interface vpls_csr_if import vpls_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### design/vpls_reach.sv
// vpls_reach: three-stage squared-distance test of one chunk row of lights
// depends on vpls_pkg; one lane per light slot
module vpls_reach import vpls_pkg::*; (
   input  logic                              clock,
   input  logic                              reset,
   input  probe_type                         probe,
   input  light_type [LIGHTS_PER_CHUNK-1:0]  lights,
   input  light_type                         vertex,
   input  logic [REACH_W-1:0]                reach,
   output verdict_type                       verdict
);

   logic [MAG_W-1:0] mag_ff [LIGHTS_PER_CHUNK][3];
   logic [SQ_W-1:0]  sq_ff  [LIGHTS_PER_CHUNK][3];
   logic [LIGHTS_PER_CHUNK-1:0] live_a_ff;
   logic [LIGHTS_PER_CHUNK-1:0] live_b_ff;
   logic valid_a_ff;
   logic valid_b_ff;
   logic valid_c_ff;
   logic hit_c_ff;
   logic hit_in;

   // stage a: per-axis distance magnitudes
   always_ff @(posedge clock) begin
      for (int i = 0; i < LIGHTS_PER_CHUNK; i++) begin
         mag_ff[i][0] <= abs_diff(lights[i].x, vertex.x);
         mag_ff[i][1] <= abs_diff(lights[i].y, vertex.y);
         mag_ff[i][2] <= abs_diff(lights[i].z, vertex.z);
      end
      live_a_ff <= probe.live;
   end

   // stage b: squares
   always_ff @(posedge clock) begin
      for (int i = 0; i < LIGHTS_PER_CHUNK; i++) begin
         for (int a = 0; a < 3; a++) begin
            sq_ff[i][a] <= mag_ff[i][a] * mag_ff[i][a];
         end
      end
      live_b_ff <= live_a_ff;
   end

   // stage c: sum and compare per lane
   always_comb begin
      hit_in = 1'b0;
      for (int i = 0; i < LIGHTS_PER_CHUNK; i++) begin
         if (live_b_ff[i] && ((DIST_W'(sq_ff[i][0]) + DIST_W'(sq_ff[i][1])
                               + DIST_W'(sq_ff[i][2])) < reach)) begin
            hit_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         valid_a_ff <= probe.valid;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      hit_c_ff <= hit_in;
   end

   assign verdict = '{valid: valid_c_ff, hit: hit_c_ff};

endmodule

### design/vertex_point_light_shade_top.sv
// vertex_point_light_shade_top: per-vertex point-light shading over a chunked world
// depends on vpls_pkg, vpls_if and vpls_reach
//
// req_bus carries one command per beat: shade a vertex, write one light slot, or set
// a chunk's light count. Only shade beats give a beat on rsp_bus (color_out, lit).
// csr_bus writes falloff (index 0) and reach_squared (index 1); it is always ready.
// For a shade beat, the sequencer reads the 3x3 neighborhood of chunks one chunk at
// a time from the light memory, then a four-stage distance pipeline (registered
// read, magnitudes, squares, sum and compare) drains before the response is formed.
// One shade beat is in flight at a time; req_bus is ready whenever no shade is in
// progress, so a new shade beat is accepted only after the previous one is done.
// The response sits in an output register; new commands are accepted while it waits,
// and a following shade stalls at its end until the earlier response is taken.
// Reset clears the chunk light counts at once through per-chunk valid bits,
// sets falloff to 0 and reach_squared to 65536. Light positions are undefined
// until written.
module vertex_point_light_shade_top import vpls_pkg::*; (
   input logic        clock,
   input logic        reset,
   vpls_req_if.sink   req_bus,
   vpls_rsp_if.source rsp_bus,
   vpls_csr_if.sink   csr_bus
);

   state_type state_ff, state_in;

   logic [FALLOFF_W-1:0] falloff_ff;
   logic [REACH_W-1:0]   reach_ff;

   logic [2:0]         col_ff;
   logic [2:0]         row_ff;
   light_type          vertex_ff;
   logic [COLOR_W-1:0] color_ff;
   logic [1:0]         off_c_ff;
   logic [1:0]         off_r_ff;
   logic [PROBE_CNT_W-1:0] ret_cnt_ff;
   logic               hit_acc_ff;

   logic               rsp_valid_ff;
   logic [COLOR_W-1:0] rsp_color_ff, rsp_color_in;
   logic               rsp_lit_ff, rsp_lit_in;

   light_type [LIGHTS_PER_CHUNK-1:0] light_mem [CHUNKS];
   light_type [LIGHTS_PER_CHUNK-1:0] light_rd_ff;
   logic [COUNT_W-1:0] cnt_mem [CHUNKS];
   logic [COUNT_W-1:0] cnt_rd_ff;
   logic [CHUNKS-1:0]  cnt_vld_ff;
   logic               cnt_vld_rd_ff;
   logic               rd_inb_ff;
   logic               rd_valid_ff;

   logic req_accept, shade_start, light_we, cnt_we, w_inb;
   logic [CHUNK_W-1:0] widx, ridx;
   logic [SLOT_W-1:0]  wslot;
   logic [COUNT_W-1:0] cnt_sat;
   logic [7:0] cell_c, cell_r;
   logic p_inb, issue, issue_last, rsp_load, req_ready;
   light_type wlight;
   probe_type probe;
   verdict_type verdict;
   logic [NIB_W-1:0] r_sat, b_sat, g_sat;

   // request decode
   assign req_accept  = req_bus.valid && req_bus.ready;
   assign shade_start = req_accept && (req_bus.command == CMD_SHADE);
   assign w_inb = (8'(req_bus.home_col) < 8'(WORLD_COLS))
                  && (8'(req_bus.home_row) < 8'(WORLD_ROWS));
   assign widx  = CHUNK_W'(16'(req_bus.home_col) * 16'(WORLD_ROWS) + 16'(req_bus.home_row));
   assign wslot = SLOT_W'(req_bus.slot);
   assign light_we = req_accept && (req_bus.command == CMD_LIGHT) && w_inb
                     && (8'(req_bus.slot) < 8'(LIGHTS_PER_CHUNK));
   assign cnt_we   = req_accept && (req_bus.command == CMD_COUNT) && w_inb;
   assign cnt_sat  = (8'(req_bus.count_in) > 8'(LIGHTS_PER_CHUNK))
                     ? COUNT_W'(LIGHTS_PER_CHUNK) : COUNT_W'(req_bus.count_in);
   assign wlight.x = req_bus.pos_x;
   assign wlight.y = req_bus.pos_y;
   assign wlight.z = req_bus.pos_z;

   // neighbor cell being probed
   assign cell_c = 8'(col_ff) + 8'(off_c_ff) - 8'd1;
   assign cell_r = 8'(row_ff) + 8'(off_r_ff) - 8'd1;
   assign p_inb  = (cell_c < 8'(WORLD_COLS)) && (cell_r < 8'(WORLD_ROWS));
   assign ridx   = p_inb ? CHUNK_W'(16'(cell_c) * 16'(WORLD_ROWS) + 16'(cell_r)) : '0;
   assign issue_last = (off_c_ff == 2'd2) && (off_r_ff == 2'd2);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (shade_start) state_in = ST_ISSUE;
         ST_ISSUE: if (issue_last) state_in = ST_WAIT;
         ST_WAIT:  if (ret_cnt_ff == PROBE_CNT_W'(PROBES)) state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid_ff || rsp_bus.ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_ISSUE: issue = 1'b1;
         ST_WAIT:  ;
         ST_DONE:  rsp_load = !rsp_valid_ff || rsp_bus.ready;
         default:  ;
      endcase
   end

   assign req_bus.ready = req_ready;
   assign csr_bus.ready = 1'b1;

   // light and count memories
   always_ff @(posedge clock) begin
      if (light_we) begin
         light_mem[widx][wslot] <= wlight;
      end
      if (cnt_we) begin
         cnt_mem[widx] <= cnt_sat;
      end
      light_rd_ff <= light_mem[ridx];
      cnt_rd_ff   <= cnt_mem[ridx];
      rd_inb_ff   <= p_inb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff    <= '0;
         cnt_vld_rd_ff <= 1'b0;
         rd_valid_ff   <= 1'b0;
      end else begin
         if (cnt_we) begin
            cnt_vld_ff[widx] <= 1'b1;
         end
         cnt_vld_rd_ff <= cnt_vld_ff[ridx];
         rd_valid_ff   <= issue;
      end
   end

   always_comb begin
      probe.valid = rd_valid_ff;
      for (int i = 0; i < LIGHTS_PER_CHUNK; i++) begin
         probe.live[i] = rd_inb_ff && cnt_vld_rd_ff && (8'(i) < 8'(cnt_rd_ff));
      end
   end

   vpls_reach u_reach (
      .clock   (clock),
      .reset   (reset),
      .probe   (probe),
      .lights  (light_rd_ff),
      .vertex  (vertex_ff),
      .reach   (reach_ff),
      .verdict (verdict)
   );

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         falloff_ff <= '0;
         reach_ff   <= REACH_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_FALLOFF: falloff_ff <= csr_bus.data[FALLOFF_W-1:0];
            CSR_REACH:   reach_ff   <= csr_bus.data[REACH_W-1:0];
            default:     ;
         endcase
      end
   end

   // shade item payload
   always_ff @(posedge clock) begin
      if (shade_start) begin
         col_ff      <= req_bus.home_col;
         row_ff      <= req_bus.home_row;
         vertex_ff   <= wlight;
         color_ff    <= req_bus.color_in;
      end
   end

   // sequencer control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         off_c_ff   <= '0;
         off_r_ff   <= '0;
         ret_cnt_ff <= '0;
         hit_acc_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (shade_start) begin
            off_c_ff   <= '0;
            off_r_ff   <= '0;
            ret_cnt_ff <= '0;
            hit_acc_ff <= 1'b0;
         end else begin
            if (issue) begin
               if (off_r_ff == 2'd2) begin
                  off_r_ff <= '0;
                  off_c_ff <= off_c_ff + 2'd1;
               end else begin
                  off_r_ff <= off_r_ff + 2'd1;
               end
            end
            if (verdict.valid) begin
               ret_cnt_ff <= ret_cnt_ff + PROBE_CNT_W'(1);
               if (verdict.hit) begin
                  hit_acc_ff <= 1'b1;
               end
            end
         end
      end
   end

   // shaded color
   assign r_sat = sat_sub(color_ff[3:0], falloff_ff);
   assign b_sat = sat_sub(color_ff[11:8], falloff_ff);
   assign g_sat = sat_sub(color_ff[15:12], falloff_ff);

   always_comb begin
      if (falloff_ff == '0) begin
         rsp_color_in = color_ff;
         rsp_lit_in   = 1'b0;
      end else if (hit_acc_ff) begin
         rsp_color_in = {color_ff[15:12], b_sat, 4'b0000, color_ff[3:0]};
         rsp_lit_in   = 1'b1;
      end else begin
         rsp_color_in = {g_sat, b_sat, 4'b0000, r_sat};
         rsp_lit_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_color_ff <= rsp_color_in;
         rsp_lit_ff   <= rsp_lit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.color_out = rsp_color_ff;
   assign rsp_bus.lit       = rsp_lit_ff;

   a_ret_bound: assert property (@(posedge clock) disable iff (reset)
      ret_cnt_ff <= PROBE_CNT_W'(PROBES))
      else $error("more probe verdicts than neighbor cells");

   a_verdict_busy: assert property (@(posedge clock) disable iff (reset)
      verdict.valid |-> (state_ff == ST_ISSUE || state_ff == ST_WAIT))
      else $error("probe verdict outside a shade item");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("loaded response not presented");

   a_lit_nibble: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_lit_ff) |-> (rsp_color_ff[7:4] == 4'b0000))
      else $error("lit response keeps bits 7:4");

endmodule
